[rtl/epm_pkg.sv]
// ----------------------------------------------------------------------------
// epm_pkg: shared types and constants for the echo ping monitor
// Queue entry, result and configuration structs, sequencer states, register
// indexes and field codes.
// ----------------------------------------------------------------------------
package epm_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_HOST_0        = 3'd0;
  localparam logic [2:0] REG_PROBE_LIMIT   = 3'd4;
  localparam logic [2:0] REG_PROBE_IVAL    = 3'd5;
  localparam logic [2:0] REG_MIN_REPLY_LEN = 3'd6;

  // Reset values of the registers
  localparam logic [47:0] HOST_ENTRY_RST    = 48'hFFFF_FFFF_0000;
  localparam logic [7:0]  PROBE_LIMIT_RST   = 8'd4;
  localparam logic [31:0] PROBE_IVAL_RST    = 32'd100;
  localparam logic [15:0] MIN_REPLY_LEN_RST = 16'd64;

  // Address that marks a host slot as unused
  localparam logic [31:0] ADDR_OFF = 32'hFFFF_FFFF;

  // Field codes
  localparam logic       REQ_POLL        = 1'b0;
  localparam logic       REQ_REPLY       = 1'b1;
  localparam logic [7:0] KIND_ECHO_REPLY = 8'd0;
  localparam logic       RES_REPLY       = 1'b0;
  localparam logic       RES_REQUEST     = 1'b1;

  // One classified poll waiting for the back end
  typedef struct packed {
    logic        reply_ok;
    logic [31:0] now_time;
    logic [31:0] src_ip;
    logic [15:0] reply_ident;
    logic [15:0] reply_seq;
  } qent_t;

  // One result item
  typedef struct packed {
    logic        result_kind;
    logic [1:0]  host_index;
    logic [31:0] dest_ip;
    logic [15:0] echo_ident;
    logic [7:0]  probe_seq;
    logic [7:0]  replies_seen;
    logic        is_last;
  } res_t;

  // Shared scalar configuration
  typedef struct packed {
    logic [7:0]  probe_limit;
    logic [31:0] probe_interval;
    logic [15:0] min_reply_len;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_REPLY,
    S_SCAN,
    S_FLUSH
  } state_t;

endpackage

[rtl/epm_front.sv]
// ----------------------------------------------------------------------------
// epm_front: input side of the echo ping monitor
// Accepts poll items, decides whether the carried reply qualifies and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module epm_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          req_type,
  input  logic [31:0]   now_time,
  input  logic [31:0]   src_ip,
  input  logic [15:0]   reply_len,
  input  logic [7:0]    icmp_kind,
  input  logic [15:0]   reply_ident,
  input  logic [15:0]   reply_seq,
  input  logic [15:0]   min_reply_len,
  output logic          q_valid,
  output epm_pkg::qent_t q_data,
  input  logic          q_pop
);
  import epm_pkg::*;

  qent_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  qent_t       ent;

  // Classify the item: only a well-formed echo reply is worth matching
  always_comb begin
    ent.reply_ok    = (req_type == REQ_REPLY) && (icmp_kind == KIND_ECHO_REPLY) &&
                      (reply_len >= min_reply_len);
    ent.now_time    = now_time;
    ent.src_ip      = src_ip;
    ent.reply_ident = reply_ident;
    ent.reply_seq   = reply_seq;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot[rd_ptr];

  // Store accepted items
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= ent;
    end
  end

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (q_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[rtl/epm_back.sv]
// ----------------------------------------------------------------------------
// epm_back: host sequencer of the echo ping monitor
// Matches the reply of one queued poll against all hosts, then walks the
// hosts one per cycle unless a probe stalls, deciding on probes. One
// result is held back so that the last one of an item can be marked.
// ----------------------------------------------------------------------------
module epm_back #(
  parameter int NUM_HOSTS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [47:0]    host_entry [NUM_HOSTS],
  input  epm_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  epm_pkg::qent_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output epm_pkg::res_t  out_res
);
  import epm_pkg::*;

  localparam int HW = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;

  state_t        state;
  state_t        state_next;
  logic [HW-1:0] hidx;
  qent_t         cur;
  res_t          pend;
  logic          pend_valid;
  res_t          pend_out;

  logic [7:0]    next_seq       [NUM_HOSTS];
  logic [7:0]    reply_count    [NUM_HOSTS];
  logic [31:0]   last_send_time [NUM_HOSTS];

  logic          out_free;
  logic          out_load;
  logic          reply_hit;
  logic [HW-1:0] match_idx;
  logic [7:0]    match_cnt;
  res_t          reply_res;
  logic [31:0]   h_addr;
  logic [7:0]    h_seq;
  logic [7:0]    h_cnt;
  logic [31:0]   h_elapsed;
  logic          fire;
  logic          scan_hold;
  logic          scan_end;
  logic          flush_done;
  logic          take;
  res_t          probe_res;

  assign out_free = !out_valid || !out_stall;

  // Find the lowest host that the reply belongs to
  always_comb begin
    reply_hit = 1'b0;
    match_idx = '0;
    for (int i = 0; i < NUM_HOSTS; i++) begin
      if (!reply_hit && cur.reply_ok &&
          host_entry[i][47:16] == cur.src_ip &&
          host_entry[i][15:0] == cur.reply_ident &&
          cur.reply_seq < {8'd0, next_seq[i]}) begin
        reply_hit = 1'b1;
        match_idx = HW'(i);
      end
    end
    match_cnt = (reply_count[match_idx] == 8'hFF) ? 8'hFF :
                reply_count[match_idx] + 8'd1;
    reply_res.result_kind  = RES_REPLY;
    reply_res.host_index   = 2'(match_idx);
    reply_res.dest_ip      = host_entry[match_idx][47:16];
    reply_res.echo_ident   = host_entry[match_idx][15:0];
    reply_res.probe_seq    = next_seq[match_idx];
    reply_res.replies_seen = match_cnt;
    reply_res.is_last      = 1'b0;
  end

  // Probe decision for the host under the scan pointer
  always_comb begin
    h_addr    = host_entry[hidx][47:16];
    h_seq     = next_seq[hidx];
    h_cnt     = reply_count[hidx];
    h_elapsed = cur.now_time - last_send_time[hidx];
    fire      = (state == S_SCAN) && (h_addr != ADDR_OFF) &&
                (h_cnt != cfg.probe_limit) && (h_seq < cfg.probe_limit) &&
                (h_elapsed > cfg.probe_interval);
    probe_res.result_kind  = RES_REQUEST;
    probe_res.host_index   = 2'(hidx);
    probe_res.dest_ip      = h_addr;
    probe_res.echo_ident   = host_entry[hidx][15:0];
    probe_res.probe_seq    = h_seq;
    probe_res.replies_seen = h_cnt;
    probe_res.is_last      = 1'b0;
  end

  // Stall a probe while the held result cannot move on
  assign scan_hold  = fire && pend_valid && !out_free;
  assign scan_end   = (hidx == HW'(NUM_HOSTS - 1));
  assign flush_done = (state == S_FLUSH) && (!pend_valid || out_free);
  assign take       = q_valid && ((state == S_IDLE) || flush_done);
  assign q_pop      = take;

  // Move the held result to the output register
  assign out_load = (fire && !scan_hold && pend_valid) ||
                    ((state == S_FLUSH) && pend_valid && out_free);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (!scan_hold && scan_end) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (flush_done) begin
          state_next = take ? S_REPLY : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load the next queued poll
  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_data;
    end
  end

  always_comb begin
    pend_out         = pend;
    pend_out.is_last = (state == S_FLUSH);
  end

  // Update host state, held result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hidx       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < NUM_HOSTS; i++) begin
        next_seq[i]       <= 8'd0;
        reply_count[i]    <= 8'd0;
        last_send_time[i] <= 32'd0;
      end
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      if (out_load) begin
        out_res <= pend_out;
      end
      case (state)
        S_REPLY: begin
          hidx <= '0;
          if (reply_hit) begin
            reply_count[match_idx] <= match_cnt;
            pend                   <= reply_res;
            pend_valid             <= 1'b1;
          end
        end
        S_SCAN: begin
          if (!scan_hold) begin
            if (fire) begin
              next_seq[hidx]       <= h_seq + 8'd1;
              last_send_time[hidx] <= cur.now_time;
              pend                 <= probe_res;
              pend_valid           <= 1'b1;
            end
            if (!scan_end) begin
              hidx <= hidx + HW'(1);
            end
          end
        end
        S_FLUSH: begin
          if (pend_valid && out_free) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/echo_ping_monitor.sv]
// ----------------------------------------------------------------------------
// echo_ping_monitor: echo probe tracker for a small set of hosts
// Counts qualifying echo replies per host and issues echo requests when a
// host's probe interval has run out.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | in        | in_valid / in_stall  | req_type .. reply_seq
//   out     | out       | out_valid / out_stall| result_kind .. is_last
//   cfg     | in        | cfg_wr               | cfg_index, cfg_data
//
// In the back end an item passes through the reply match, a probe scan of
// every host and a final step that marks the last result.
// That scan of the host table sets the rate; a two-entry queue takes items
// while the scan runs. Reset clears all host counters and times at once.
// A stalled output holds the scan only when a probe must push out a result.
// ----------------------------------------------------------------------------
module echo_ping_monitor #(
  parameter int NUM_HOSTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [31:0] now_time,
  input  logic [31:0] src_ip,
  input  logic [15:0] reply_len,
  input  logic [7:0]  icmp_kind,
  input  logic [15:0] reply_ident,
  input  logic [15:0] reply_seq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        result_kind,
  output logic [1:0]  host_index,
  output logic [31:0] dest_ip,
  output logic [15:0] echo_ident,
  output logic [7:0]  probe_seq,
  output logic [7:0]  replies_seen,
  output logic        is_last
);
  import epm_pkg::*;

  logic [47:0] host_entry [NUM_HOSTS];
  cfg_t        cfg;
  logic        q_valid;
  qent_t       q_data;
  logic        q_pop;
  res_t        out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_HOSTS; i++) begin
        host_entry[i] <= HOST_ENTRY_RST;
      end
      cfg.probe_limit    <= PROBE_LIMIT_RST;
      cfg.probe_interval <= PROBE_IVAL_RST;
      cfg.min_reply_len  <= MIN_REPLY_LEN_RST;
    end else if (cfg_wr) begin
      for (int i = 0; i < NUM_HOSTS; i++) begin
        if (cfg_index == REG_HOST_0 + 3'(i)) begin
          host_entry[i] <= cfg_data;
        end
      end
      case (cfg_index)
        REG_PROBE_LIMIT:   cfg.probe_limit    <= cfg_data[7:0];
        REG_PROBE_IVAL:    cfg.probe_interval <= cfg_data[31:0];
        REG_MIN_REPLY_LEN: cfg.min_reply_len  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  epm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .now_time      (now_time),
    .src_ip        (src_ip),
    .reply_len     (reply_len),
    .icmp_kind     (icmp_kind),
    .reply_ident   (reply_ident),
    .reply_seq     (reply_seq),
    .min_reply_len (cfg.min_reply_len),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop)
  );

  epm_back #(
    .NUM_HOSTS (NUM_HOSTS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .host_entry (host_entry),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res)
  );

  // Split the result onto its ports
  assign result_kind  = out_res.result_kind;
  assign host_index   = out_res.host_index;
  assign dest_ip      = out_res.dest_ip;
  assign echo_ident   = out_res.echo_ident;
  assign probe_seq    = out_res.probe_seq;
  assign replies_seen = out_res.replies_seen;
  assign is_last      = out_res.is_last;

  // An accepted item is waiting in the queue on the next cycle
  a_push_queued: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> q_valid)
    else $error("accepted item not queued");

  // The back end only takes from a non-empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // No result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result presented after reset");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the echo ping monitor
// Drives polls and received echo replies through the valid/stall input,
// tracks the expected probe requests and counted replies per host in a
// software copy of the host table, and compares every result field by field.
// Covers reset defaults, reply qualification, time wrap, probe limit
// extremes, long output back-pressure and a reply flood up to count
// saturation, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
  import epm_pkg::*;

  localparam int HOSTS = 4;
  localparam int IDLE_CYCLES = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_PRINTED = 40;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic        req_type;
    logic [31:0] now_time;
    logic [31:0] src_ip;
    logic [15:0] reply_len;
    logic [7:0]  icmp_kind;
    logic [15:0] reply_ident;
    logic [15:0] reply_seq;
  } poll_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  logic [31:0] now_time;
  logic [31:0] src_ip;
  logic [15:0] reply_len;
  logic [7:0]  icmp_kind;
  logic [15:0] reply_ident;
  logic [15:0] reply_seq;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [1:0]  host_index;
  logic [31:0] dest_ip;
  logic [15:0] echo_ident;
  logic [7:0]  probe_seq;
  logic [7:0]  replies_seen;
  logic        is_last;

  // Software copy of the host table and registers
  logic [47:0] host_entry [HOSTS];
  logic [7:0]  probe_limit;
  logic [31:0] probe_interval;
  logic [15:0] min_reply_len;
  logic [7:0]  next_seq [HOSTS];
  logic [7:0]  reply_count [HOSTS];
  logic [31:0] last_probe_time [HOSTS];

  res_t        pending_results[$];
  int          errors;
  int          cycles;
  int          hold_cycles;
  int          stall_left;
  bit          idle_on;
  logic [31:0] clock_now;

  echo_ping_monitor #(
    .NUM_HOSTS(HOSTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr(cfg_wr),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .now_time(now_time),
    .src_ip(src_ip),
    .reply_len(reply_len),
    .icmp_kind(icmp_kind),
    .reply_ident(reply_ident),
    .reply_seq(reply_seq),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .host_index(host_index),
    .dest_ip(dest_ip),
    .echo_ident(echo_ident),
    .probe_seq(probe_seq),
    .replies_seen(replies_seen),
    .is_last(is_last)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive the output stall: a forced hold-off first, else random bursts
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 2) == 0) stall_left = gap_len();
    end
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Compare each accepted result with the oldest expected one
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result kind %0d host %0d", result_kind, host_index));
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", result_kind, want.result_kind);
        check_field("host_index", host_index, want.host_index);
        check_field("dest_ip", dest_ip, want.dest_ip);
        check_field("echo_ident", echo_ident, want.echo_ident);
        check_field("probe_seq", probe_seq, want.probe_seq);
        check_field("replies_seen", replies_seen, want.replies_seen);
        check_field("is_last", is_last, want.is_last);
      end
    end
  end

  function automatic res_t host_result(input logic kind, input int h);
    res_t r;
    r.result_kind  = kind;
    r.host_index   = 2'(h);
    r.dest_ip      = host_entry[h][47:16];
    r.echo_ident   = host_entry[h][15:0];
    r.probe_seq    = next_seq[h];
    r.replies_seen = reply_count[h];
    r.is_last      = 1'b0;
    return r;
  endfunction

  // Advance the host table by one poll and queue the results it causes
  function automatic void apply_poll(input poll_t p);
    res_t        batch[$];
    res_t        r;
    bit          counted;
    logic [31:0] elapsed;
    int          h;
    counted = 1'b0;
    // match the reply against the lowest qualifying host
    if (p.req_type == REQ_REPLY && p.icmp_kind == KIND_ECHO_REPLY &&
        p.reply_len >= min_reply_len) begin
      for (h = 0; h < HOSTS; h++) begin
        if (!counted && host_entry[h][47:16] == p.src_ip &&
            host_entry[h][15:0] == p.reply_ident && p.reply_seq < next_seq[h]) begin
          if (reply_count[h] != 8'hFF) reply_count[h] = reply_count[h] + 8'd1;
          batch.push_back(host_result(RES_REPLY, h));
          counted = 1'b1;
        end
      end
    end
    // scan the hosts for probes that are due
    for (h = 0; h < HOSTS; h++) begin
      if (host_entry[h][47:16] != ADDR_OFF && reply_count[h] != probe_limit) begin
        elapsed = p.now_time - last_probe_time[h];
        if (next_seq[h] < probe_limit && elapsed > probe_interval) begin
          batch.push_back(host_result(RES_REQUEST, h));
          next_seq[h] = next_seq[h] + 8'd1;
          last_probe_time[h] = p.now_time;
        end
      end
    end
    if (batch.size() > 0) begin
      r = batch.pop_back();
      r.is_last = 1'b1;
      batch.push_back(r);
    end
    foreach (batch[i]) pending_results.push_back(batch[i]);
  endfunction

  // Offer one item; valid stays high until the next item or a pause
  task automatic send_item(input logic req, input logic [31:0] now,
                           input logic [31:0] src, input logic [15:0] len,
                           input logic [7:0] kind, input logic [15:0] ident,
                           input logic [15:0] seq);
    poll_t p;
    int    gap;
    p = '{req, now, src, len, kind, ident, seq};
    gap = idle_on ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type    <= req;
    now_time    <= now;
    src_ip      <= src;
    reply_len   <= len;
    icmp_kind   <= kind;
    reply_ident <= ident;
    reply_seq   <= seq;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    apply_poll(p);
  endtask

  task automatic poll_at(input logic [31:0] now);
    send_item(REQ_POLL, now, 32'd0, 16'd0, 8'd0, 16'd0, 16'd0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    @(negedge clk);
    cfg_wr    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < REG_PROBE_LIMIT) host_entry[idx[1:0]] = data;
    else if (idx == REG_PROBE_LIMIT) probe_limit = data[7:0];
    else if (idx == REG_PROBE_IVAL) probe_interval = data[31:0];
    else if (idx == REG_MIN_REPLY_LEN) min_reply_len = data[15:0];
    @(negedge clk);
    cfg_wr <= 1'b0;
  endtask

  task automatic set_host(input int h, input logic [31:0] addr, input logic [15:0] ident);
    write_reg(REG_HOST_0 + 3'(h), {addr, ident});
  endtask

  // Drop valid, drain the expected results, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // Highest sequence handed out so far, to keep the limit above it
  function automatic logic [7:0] limit_above_seq(input int extra);
    int top;
    top = 0;
    foreach (next_seq[i]) if (next_seq[i] > top) top = next_seq[i];
    top = top + extra;
    return (top > 255) ? 8'd255 : 8'(top);
  endfunction

  task automatic randomise_hosts();
    logic [31:0] shared_addr;
    logic [15:0] shared_id;
    int          pick;
    shared_addr = $urandom;
    shared_id = 16'($urandom);
    for (int h = 0; h < HOSTS; h++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) set_host(h, shared_addr, shared_id);
      else if (pick < 4) set_host(h, ADDR_OFF, 16'($urandom));
      else set_host(h, $urandom, 16'($urandom));
    end
  endtask

  // One random item: mostly clean replies to a host, the rest near misses
  task automatic random_item(input int focus, input int clean_pct);
    int          h;
    int          pick;
    logic [15:0] seq;
    logic [15:0] len;
    logic [31:0] addr;
    logic [15:0] ident;
    h = (focus < 0) ? $urandom_range(0, HOSTS - 1) : focus;
    addr = host_entry[h][47:16];
    ident = host_entry[h][15:0];
    clock_now = clock_now + $urandom_range(0, 60);
    if ($urandom_range(0, 19) == 0) clock_now = $urandom;
    len = (min_reply_len > 16'hFF00) ? 16'hFFFF : min_reply_len + 16'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < clean_pct) begin
      seq = (next_seq[h] == 0) ? 16'd0 : 16'($urandom_range(0, next_seq[h] - 1));
      send_item(REQ_REPLY, clock_now, addr, len, KIND_ECHO_REPLY, ident, seq);
    end else begin
      pick = $urandom_range(0, 4);
      case (pick)
        0: send_item(REQ_POLL, clock_now, $urandom, 16'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom));
        1: send_item(1'($urandom), clock_now, $urandom, 16'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom));
        // sequence not sent yet
        2: send_item(REQ_REPLY, clock_now, addr, len, KIND_ECHO_REPLY, ident,
                     16'(next_seq[h]) + 16'($urandom_range(0, 3)));
        // too short, or the wrong type
        3: send_item(REQ_REPLY, clock_now, addr,
                     $urandom_range(0, 1) ? min_reply_len - 16'd1 : len,
                     8'($urandom_range(1, 255)), ident, 16'd0);
        default: send_item(REQ_REPLY, clock_now, addr ^ (32'd1 << $urandom_range(0, 31)),
                           len, KIND_ECHO_REPLY, ident ^ 16'($urandom_range(0, 1)), 16'd0);
      endcase
    end
  endtask

  // Hosts are disabled after reset: nothing comes out
  task automatic test_idle_defaults();
    poll_at(32'hFFFF_FFFF);
    send_item(REQ_REPLY, 32'd5, ADDR_OFF, 16'd64, KIND_ECHO_REPLY, 16'd0, 16'd0);
    settle();
  endtask

  // Probes, reply qualification, duplicate hosts and a full five-result item
  task automatic test_probe_and_reply();
    logic [31:0] a;
    logic [15:0] id;
    a = 32'hC0A8_0101;
    id = 16'h1234;
    set_host(0, a, id);
    set_host(1, a, id);
    set_host(2, 32'd0, 16'd0);
    set_host(3, 32'hFFFF_FFFE, 16'hFFFF);
    write_reg(REG_PROBE_LIMIT, 48'd3);
    write_reg(REG_PROBE_IVAL, 48'd10);
    write_reg(REG_MIN_REPLY_LEN, 48'd64);
    poll_at(32'd11);
    send_item(REQ_REPLY, 32'd11, a, 16'd64, KIND_ECHO_REPLY, id, 16'd0);
    send_item(REQ_REPLY, 32'd11, a, 16'd63, KIND_ECHO_REPLY, id, 16'd0);
    send_item(REQ_REPLY, 32'd11, a, 16'd64, 8'hFF, id, 16'd0);
    send_item(REQ_POLL, 32'd11, a, 16'd64, KIND_ECHO_REPLY, id, 16'd0);
    send_item(REQ_REPLY, 32'd11, a, 16'd64, KIND_ECHO_REPLY, id, 16'd1);
    send_item(REQ_REPLY, 32'd11, a, 16'd64, KIND_ECHO_REPLY, id + 16'd1, 16'd0);
    poll_at(32'd21);
    poll_at(32'd22);
    send_item(REQ_REPLY, 32'd22, 32'hFFFF_FFFE, 16'hFFFF, KIND_ECHO_REPLY, 16'hFFFF,
              16'hFFFF);
    send_item(REQ_REPLY, 32'd22, 32'd0, 16'hFFFF, KIND_ECHO_REPLY, 16'd0, 16'd1);
    send_item(REQ_REPLY, 32'd40, a, 16'd100, KIND_ECHO_REPLY, id, 16'd1);
    send_item(REQ_REPLY, 32'd40, a, 16'd64, KIND_ECHO_REPLY, id, 16'd2);
    poll_at(32'd60);
    settle();
  endtask

  // Elapsed time taken across the 32-bit wrap, interval at both extremes
  task automatic test_time_wrap();
    write_reg(REG_PROBE_LIMIT, 48'd255);
    write_reg(REG_PROBE_IVAL, 48'd1000);
    poll_at(32'hFFFF_FFF0);
    poll_at(32'h0000_0010);
    poll_at(32'h0000_03E0);
    settle();
    write_reg(REG_PROBE_IVAL, 48'hFFFF_FFFF);
    poll_at(32'h0000_03DF);
    settle();
    write_reg(REG_PROBE_IVAL, 48'd0);
    poll_at(32'h0000_03E0);
    poll_at(32'h0000_03E1);
    settle();
  endtask

  // Zero probe limit, an unused register index and reply length extremes
  task automatic test_zero_limit();
    write_reg(REG_PROBE_LIMIT, 48'd0);
    poll_at(32'h0000_5000);
    send_item(REQ_REPLY, 32'h0000_5000, 32'hC0A8_0101, 16'd64, KIND_ECHO_REPLY,
              16'h1234, 16'd0);
    settle();
    write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
    set_host(3, ADDR_OFF, 16'hFFFF);
    write_reg(REG_MIN_REPLY_LEN, 48'd0);
    poll_at(32'h0000_6000);
    send_item(REQ_REPLY, 32'h0000_6000, ADDR_OFF, 16'd64, KIND_ECHO_REPLY, 16'hFFFF, 16'd0);
    send_item(REQ_REPLY, 32'h0000_6000, 32'd0, 16'd0, KIND_ECHO_REPLY, 16'd0, 16'd0);
    settle();
    write_reg(REG_MIN_REPLY_LEN, 48'hFFFF);
    send_item(REQ_REPLY, 32'h0000_6000, 32'd0, 16'hFFFE, KIND_ECHO_REPLY, 16'd0, 16'd0);
    send_item(REQ_REPLY, 32'h0000_6000, 32'd0, 16'hFFFF, KIND_ECHO_REPLY, 16'd0, 16'd0);
    settle();
  endtask

  // Random items under several random settings, one phase with a limit of one
  task automatic test_random_mix();
    clock_now = 32'h0001_0000;
    for (int phase = 0; phase < 3; phase++) begin
      randomise_hosts();
      write_reg(REG_PROBE_LIMIT, (phase == 1) ? 48'd1 : 48'(limit_above_seq(
                $urandom_range(2, 20))));
      write_reg(REG_PROBE_IVAL, 48'($urandom_range(0, 40)));
      write_reg(REG_MIN_REPLY_LEN, 48'($urandom_range(0, 128)));
      idle_on = (phase != 1);
      repeat (30) random_item(-1, 70);
      settle();
    end
    idle_on = 1'b1;
  endtask

  // Hold the output off for a long stretch while probes keep coming
  task automatic test_backpressure();
    write_reg(REG_PROBE_LIMIT, 48'd255);
    write_reg(REG_PROBE_IVAL, 48'd0);
    idle_on = 1'b0;
    hold_cycles = 300;
    for (int i = 0; i < 24; i++) begin
      clock_now = clock_now + 32'd1;
      poll_at(clock_now);
    end
    settle();
    idle_on = 1'b1;
  endtask

  // Flood one host with valid replies until its count saturates
  task automatic test_reply_flood();
    logic [31:0] a;
    a = $urandom;
    a[0] = 1'b0;
    set_host(0, a, 16'($urandom));
    write_reg(REG_PROBE_LIMIT, 48'd255);
    write_reg(REG_PROBE_IVAL, 48'd30);
    write_reg(REG_MIN_REPLY_LEN, 48'($urandom_range(0, 1500)));
    repeat (280) random_item(0, 95);
    settle();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_wr = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_POLL;
    now_time = '0;
    src_ip = '0;
    reply_len = '0;
    icmp_kind = '0;
    reply_ident = '0;
    reply_seq = '0;
    out_stall = 1'b0;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    stall_left = 0;
    idle_on = 1'b1;
    clock_now = '0;
    // power-on state of the host table
    for (int h = 0; h < HOSTS; h++) begin
      host_entry[h] = HOST_ENTRY_RST;
      next_seq[h] = '0;
      reply_count[h] = '0;
      last_probe_time[h] = '0;
    end
    probe_limit = PROBE_LIMIT_RST;
    probe_interval = PROBE_IVAL_RST;
    min_reply_len = MIN_REPLY_LEN_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_defaults();
    test_probe_and_reply();
    test_time_wrap();
    test_zero_limit();
    test_random_mix();
    test_backpressure();
    test_reply_flood();
    settle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
